@@ hdl/philox_counter_rng_dropout_macros.svh @@
// Assertion macros shared by the Philox dropout generator RTL.
`ifndef PHILOX_COUNTER_RNG_DROPOUT_MACROS_SVH
`define PHILOX_COUNTER_RNG_DROPOUT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define PCRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcrd: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define PCRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcrd: next-cycle check failed");

`endif

@@ hdl/pcrd_pkg.sv @@
// Types, constants and helper functions of the Philox dropout generator.
package pcrd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned TopW    = 24;
  localparam int unsigned ThrW    = 25;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] MulA         = 32'hD2511F53;
  localparam logic [WordW-1:0] MulB         = 32'hCD9E8D57;
  localparam logic [WordW-1:0] WeylA        = 32'h9E3779B9;
  localparam logic [WordW-1:0] WeylB        = 32'hBB67AE85;
  localparam logic [WordW-1:0] KeyHighReset = 32'h1BD11BDA;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyLow        = 2'd0,
    CfgKeyHigh       = 2'd1,
    CfgDropThreshold = 2'd2,
    CfgDropoutEnable = 2'd3
  } cfg_reg_e;

  // Four state words, index 0 is word 0
  typedef logic [3:0][WordW-1:0] words_t;

  // Registered half of a round: products and keyed pass-through words
  typedef struct packed {
    logic [WordW-1:0] hia;
    logic [WordW-1:0] loa;
    logic [WordW-1:0] hib;
    logic [WordW-1:0] lob;
    logic [WordW-1:0] t1;
    logic [WordW-1:0] t3;
  } part_t;

  typedef struct packed {
    logic [WordW-1:0] counter_word0;
    logic [WordW-1:0] counter_word1;
    logic [WordW-1:0] counter_word2;
    logic [WordW-1:0] counter_word3;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] random_word0;
    logic [WordW-1:0] random_word1;
    logic [WordW-1:0] random_word2;
    logic [WordW-1:0] random_word3;
    logic             drop_flag;
  } out_item_t;

  // Close a round: fold the high products into the keyed words and permute
  function automatic words_t round_finish(part_t p);
    words_t w;
    w[0] = p.hib ^ p.t1;
    w[1] = p.lob;
    w[2] = p.hia ^ p.t3;
    w[3] = p.loa;
    return w;
  endfunction

endpackage

@@ hdl/philox_counter_rng_dropout.sv @@
// Top level of the Philox 4x32 counter generator with dropout flag.
// Throughput: one transaction per cycle without output stalls; each round is one
// pipeline stage with one pair of 32x32 multipliers, and the flag compare sits in the
// output register stage, which a transaction enters after the round stages in order.
// Reset clears all stage valid bits and loads the key, threshold and enable defaults.
`include "philox_counter_rng_dropout_macros.svh"

module philox_counter_rng_dropout
  import pcrd_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o
);

  logic [WordW-1:0] key_low_q;
  logic [WordW-1:0] key_high_q;
  logic [ThrW-1:0]  drop_threshold_q;
  logic             dropout_enable_q;

  logic   st_valid [ROUND_COUNT+1];
  logic   st_ready [ROUND_COUNT+1];
  words_t st_words [ROUND_COUNT];
  part_t  st_part  [ROUND_COUNT];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q        <= '0;
      key_high_q       <= KeyHighReset;
      drop_threshold_q <= '0;
      dropout_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgKeyLow:        key_low_q        <= cfg_data_i;
        CfgKeyHigh:       key_high_q       <= cfg_data_i;
        CfgDropThreshold: drop_threshold_q <= cfg_data_i[ThrW-1:0];
        CfgDropoutEnable: dropout_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Feed the counter into the first round
  assign st_valid[0] = in_valid_i;
  assign in_ready_o  = st_ready[0];
  assign st_words[0] = {in_data_i.counter_word3, in_data_i.counter_word2,
                        in_data_i.counter_word1, in_data_i.counter_word0};

  // Chain the round stages, each with its Weyl-advanced key
  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    logic [WordW-1:0] key_lo, key_hi;

    assign key_lo = key_low_q + (32'(r) * WeylA);
    assign key_hi = key_high_q + (32'(r) * WeylB);

    if (r > 0) begin : g_link
      assign st_words[r] = round_finish(st_part[r-1]);
    end

    pcrd_round u_round (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[r]),
      .in_ready_o  (st_ready[r]),
      .in_words_i  (st_words[r]),
      .key_lo_i    (key_lo),
      .key_hi_i    (key_hi),
      .out_valid_o (st_valid[r+1]),
      .out_ready_i (st_ready[r+1]),
      .out_part_o  (st_part[r])
    );
  end

  // Close the last round and decide the drop flag
  pcrd_drop u_drop (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (st_valid[ROUND_COUNT]),
    .in_ready_o       (st_ready[ROUND_COUNT]),
    .in_part_i        (st_part[ROUND_COUNT-1]),
    .drop_threshold_i (drop_threshold_q),
    .dropout_enable_i (dropout_enable_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_o       (out_data_o)
  );

  // Drop flag stays low while disabled or at a zero threshold
  `PCRD_ASSERT_IMP(a_flag_disabled, out_valid_o && !dropout_enable_q, !out_data_o.drop_flag)
  `PCRD_ASSERT_IMP(a_flag_zero_thr, out_valid_o && (drop_threshold_q == '0), !out_data_o.drop_flag)
  // A stalled last round stage keeps its transaction
  `PCRD_ASSERT_NXT(a_last_hold, st_valid[ROUND_COUNT] && !st_ready[ROUND_COUNT], st_valid[ROUND_COUNT] && $stable(st_part[ROUND_COUNT-1]))

endmodule

@@ hdl/pcrd_round.sv @@
// One Philox round pipeline stage: two 32x32 products and keyed words.
module pcrd_round
  import pcrd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  words_t           in_words_i,
  input  logic [WordW-1:0] key_lo_i,
  input  logic [WordW-1:0] key_hi_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output part_t            out_part_o
);

  logic                 valid_q, valid_d;
  part_t                part_q, part_d;
  logic [2*WordW-1:0]   prod_a, prod_b;

  // Take a new transaction when empty or when the held one moves on
  assign in_ready_o = !valid_q || out_ready_i;

  // Form the products and key the pass-through words
  always_comb begin
    prod_a      = in_words_i[0] * MulA;
    prod_b      = in_words_i[2] * MulB;
    part_d.hia  = prod_a[2*WordW-1:WordW];
    part_d.loa  = prod_a[WordW-1:0];
    part_d.hib  = prod_b[2*WordW-1:WordW];
    part_d.lob  = prod_b[WordW-1:0];
    part_d.t1   = in_words_i[1] ^ key_lo_i;
    part_d.t3   = in_words_i[3] ^ key_hi_i;
    valid_d     = in_ready_o ? in_valid_i : valid_q;
  end

  // Hold the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the payload on acceptance
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      part_q <= part_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_part_o  = part_q;

endmodule

@@ hdl/pcrd_drop.sv @@
// Final stage: close the last round, form the drop flag, output register.
module pcrd_drop
  import pcrd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  part_t           in_part_i,
  input  logic [ThrW-1:0] drop_threshold_i,
  input  logic            dropout_enable_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q, data_d;
  words_t    words;

  assign in_ready_o = !valid_q || out_ready_i;

  // Compare the top 24 bits of word 0 against the threshold
  always_comb begin
    words               = round_finish(in_part_i);
    data_d.random_word0 = words[0];
    data_d.random_word1 = words[1];
    data_d.random_word2 = words[2];
    data_d.random_word3 = words[3];
    data_d.drop_flag    = dropout_enable_i &&
                          ({1'b0, words[0][WordW-1:WordW-TopW]} < drop_threshold_i);
    valid_d             = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the Philox 4x32 counter generator with dropout flag.
module tb;
  import pcrd_pkg::*;

  localparam int unsigned ROUNDS = 10;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [WordW-1:0]   cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  // Mirror of the configuration registers
  logic [WordW-1:0] cur_key_low;
  logic [WordW-1:0] cur_key_high;
  logic [ThrW-1:0]  cur_threshold;
  logic             cur_enable;

  out_item_t   pending_words[$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;

  philox_counter_rng_dropout #(
    .ROUND_COUNT(ROUNDS)
  ) DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Run the rounds on one counter under the mirrored key and flag settings
  function automatic out_item_t mix_counter(input in_item_t c);
    logic [WordW-1:0] w0, w1, w2, w3, k0, k1;
    logic [63:0]      pa, pb;
    out_item_t        r;
    w0 = c.counter_word0;
    w1 = c.counter_word1;
    w2 = c.counter_word2;
    w3 = c.counter_word3;
    k0 = cur_key_low;
    k1 = cur_key_high;
    for (int i = 0; i < ROUNDS; i++) begin
      pa = {32'd0, MulA} * {32'd0, w0};
      pb = {32'd0, MulB} * {32'd0, w2};
      w0 = pb[63:32] ^ w1 ^ k0;
      w1 = pb[31:0];
      w2 = pa[63:32] ^ w3 ^ k1;
      w3 = pa[31:0];
      k0 = k0 + WeylA;
      k1 = k1 + WeylB;
    end
    r.random_word0 = w0;
    r.random_word1 = w1;
    r.random_word2 = w2;
    r.random_word3 = w3;
    r.drop_flag    = cur_enable && ({1'b0, w0[WordW-1:WordW-TopW]} < cur_threshold);
    return r;
  endfunction

  function automatic in_item_t counter_of(input logic [WordW-1:0] a, b, c, d);
    in_item_t it;
    it.counter_word0 = a;
    it.counter_word1 = b;
    it.counter_word2 = c;
    it.counter_word3 = d;
    return it;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Offer one counter and record its expected result once accepted
  task automatic send_counter(input in_item_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_words.push_back(mix_counter(item));
  endtask

  // Hold the input until every outstanding transaction has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (ROUNDS + 4) @(posedge clk_i);
  endtask

  // Write one register; the enable stays high for back-to-back writes
  task automatic put_reg(input cfg_reg_e idx, input logic [WordW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgKeyLow:        cur_key_low   = data;
      CfgKeyHigh:       cur_key_high  = data;
      CfgDropThreshold: cur_threshold = data[ThrW-1:0];
      CfgDropoutEnable: cur_enable    = data[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [WordW-1:0] k0, k1, thr, en);
    drain_results();
    put_reg(CfgKeyLow, k0);
    put_reg(CfgKeyHigh, k1);
    put_reg(CfgDropThreshold, thr);
    put_reg(CfgDropoutEnable, en);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] want,
                             input logic [WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result transaction: %h", out_data_o);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("random_word0", want.random_word0, out_data_o.random_word0);
        check_field("random_word1", want.random_word1, out_data_o.random_word1);
        check_field("random_word2", want.random_word2, out_data_o.random_word2);
        check_field("random_word3", want.random_word3, out_data_o.random_word3);
        check_field("drop_flag", {31'd0, want.drop_flag}, {31'd0, out_data_o.drop_flag});
      end
    end
  end

  // Stall the output side at random
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold = pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Reset defaults: default key pair, flag disabled
  task automatic test_reset_defaults();
    send_counter(counter_of('0, '0, '0, '0));
    send_counter(counter_of('1, '1, '1, '1));
    send_counter(counter_of(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210));
  endtask

  // Key extremes on extreme counters
  task automatic test_key_extremes();
    load_config('0, '0, '0, '0);
    send_counter(counter_of('0, '0, '0, '0));
    send_counter(counter_of('1, '1, '1, '1));
    load_config('1, '1, '0, '0);
    send_counter(counter_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    send_counter(counter_of('1, '0, '1, '0));
  endtask

  // Flag: zero threshold, full threshold, masked register bits, disabled, midpoint
  task automatic test_drop_threshold();
    load_config(32'h1234_5678, 32'h1BD1_1BDA, '0, 32'd1);
    send_counter(counter_of(32'd1, 32'd2, 32'd3, 32'd4));
    send_counter(counter_of('1, '1, '1, '1));
    load_config(32'h1234_5678, 32'h1BD1_1BDA, 32'h0100_0000, 32'd1);
    send_counter(counter_of(32'd5, 32'd6, 32'd7, 32'd8));
    send_counter(counter_of('0, '0, '0, '0));
    load_config(32'h1234_5678, 32'h1BD1_1BDA, '1, '1);
    send_counter(counter_of(32'd9, 32'd10, 32'd11, 32'd12));
    send_counter(counter_of('1, '0, '0, '1));
    load_config(32'h1234_5678, 32'h1BD1_1BDA, '1, 32'hFFFF_FFFE);
    send_counter(counter_of(32'd13, 32'd14, 32'd15, 32'd16));
    send_counter(counter_of('0, '1, '1, '0));
    load_config(32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0080_0000, 32'd1);
    for (int i = 0; i < 4; i++) send_counter(counter_of(i, 0, i, 0));
  endtask

  // Random counters under random settings, some phases without idling
  task automatic test_random_traffic();
    logic [WordW-1:0] k0, k1, thr;
    int unsigned      roll;
    for (int phase = 0; phase < 8; phase++) begin
      k0   = pick_word();
      k1   = pick_word();
      roll = $urandom_range(0, 9);
      case (roll)
        0:       thr = '0;
        1:       thr = 32'h0100_0000;
        2:       thr = 32'h01FF_FFFF;
        3:       thr = $urandom;
        default: thr = $urandom_range(0, 32'h0100_0000);
      endcase
      load_config(k0, k1, thr, $urandom);
      calm = (phase % 3 == 0);
      for (int i = 0; i < 250; i++) begin
        // Pause the sender mid-phase until the pipeline is empty
        if (i == 125) drain_results();
        send_counter(counter_of(pick_word(), pick_word(), pick_word(), pick_word()));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgKeyLow;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cur_key_low   = '0;
    cur_key_high  = KeyHighReset;
    cur_threshold = '0;
    cur_enable    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_key_extremes();
    test_drop_threshold();
    test_random_traffic();
    drain_results();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
